FILE: sv/pdrf_pkg.sv
// ----------------------------------------------------------------------------
// pdrf_pkg: shared types and codes of the report filter
// Payload structs, per-slot entry layout, policy/reason codes, FSM states.
// ----------------------------------------------------------------------------
package pdrf_pkg;

  // Default number of slots.
  localparam int unsigned SlotCountDef = 16;

  // Item function codes.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Policy codes.
  localparam logic [1:0] POL_PERIODIC  = 2'd0;
  localparam logic [1:0] POL_ON_CHANGE = 2'd1;
  localparam logic [1:0] POL_MIXED     = 2'd2;

  // Report reasons.
  localparam logic [1:0] REASON_FIRST  = 2'd0;
  localparam logic [1:0] REASON_CHANGE = 2'd1;
  localparam logic [1:0] REASON_PERIOD = 2'd2;

  // Input item.
  typedef struct packed {
    logic               func;
    logic [3:0]         slot;
    logic signed [31:0] sample_value;
    logic [31:0]        now_sec;
    logic [1:0]         policy_in;
    logic [15:0]        interval_in;
    logic [30:0]        deadband_in;
    logic [30:0]        step_in;
  } pdrf_in_t;

  // Result item.
  typedef struct packed {
    logic [3:0]         slot_out;
    logic signed [31:0] reported_value;
    logic [1:0]         reason;
    logic [1:0]         policy_out;
    logic [31:0]        change_amount;
  } pdrf_out_t;

  // One slot of the settings and history memory.
  typedef struct packed {
    logic [1:0]         policy;
    logic [15:0]        interval;
    logic [30:0]        deadband;
    logic [30:0]        step;
    logic signed [31:0] last_reported;
    logic [31:0]        last_period_time;
  } pdrf_entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_ADJ,
    ST_ROUND,
    ST_FINISH
  } pdrf_state_e;

endpackage

FILE: sv/pdrf_if.sv
// ----------------------------------------------------------------------------
// pdrf_in_if / pdrf_out_if: valid/ready channels of the report filter
// A transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface pdrf_in_if
  import pdrf_pkg::*;
();
  logic     valid;
  logic     ready;
  pdrf_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pdrf_out_if
  import pdrf_pkg::*;
();
  logic      valid;
  logic      ready;
  pdrf_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/periodic_deadband_report_filter.sv
// ----------------------------------------------------------------------------
// periodic_deadband_report_filter: per-slot report-by-exception filter
// Decides per sample whether a slot reports, rounds the reported value to the
// slot's step and keeps the slot's last report and period reference.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A load item is taken while idle and
// writes the slot in the same cycle. A sample that does not report goes
// through the memory read and the decision and back to idle. A reporting
// sample then passes the adjust, round and finish steps; with a nonzero step
// the restoring divider first finds the rounding remainder one bit per cycle.
// Results wait in an output register, so a slow sink stalls the block only
// when a second result is ready before the first has been taken. Samples
// for slots at or above SLOT_COUNT, and slots loaded with policy code 3,
// never report. A slot must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module periodic_deadband_report_filter
  import pdrf_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pdrf_in_if.sink           in_i,
  pdrf_out_if.source        out_o
);

  localparam int unsigned IdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SlotW = 4;
  localparam int unsigned ExtW  = SlotW + IdxW;

  // Sequencer state.
  pdrf_state_e state_q, state_d;

  // Item and slot data.
  pdrf_in_t           item_q;
  logic [IdxW-1:0]    idx_q;
  pdrf_entry_t        entry_q;
  pdrf_entry_t        mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] has_rep_q;
  logic [SLOT_COUNT-1:0] has_per_q;

  // Rounding datapath.
  logic [31:0] mag_q;
  logic        neg_q;
  logic [31:0] dvd_q;
  logic [31:0] rem_q;
  logic [4:0]  cnt_q;
  logic [31:0] base_q;
  logic        up_q;
  logic signed [31:0] rounded_q;
  logic [1:0]  reason_q;
  logic [31:0] change_q;

  // Output register.
  logic      out_valid_q;
  pdrf_out_t out_q;

  // Control outputs of the sequencer.
  logic in_ready;
  logic in_xfer;
  logic finish_go;

  // Slot index decode of the incoming item.
  logic [ExtW-1:0] slot_ext;
  logic [IdxW-1:0] in_idx;
  logic            in_slot_ok;

  assign slot_ext   = {{IdxW{1'b0}}, in_i.payload.slot};
  assign in_idx     = slot_ext[IdxW-1:0];
  assign in_slot_ok = slot_ext < ExtW'(SLOT_COUNT);
  assign in_xfer    = in_i.valid && in_ready;

  // Decision logic, evaluated on the registered memory entry.
  logic               hr;
  logic               hp;
  logic signed [32:0] diff;
  logic [32:0]        diff_abs;
  logic [31:0]        change;
  logic [31:0]        elapsed;
  logic               period_due;
  logic               db_nz;
  logic               chg_ge;
  logic               report;
  logic [1:0]         reason;

  always_comb begin
    hr         = has_rep_q[idx_q];
    hp         = has_per_q[idx_q];
    diff       = {item_q.sample_value[31], item_q.sample_value}
               - {entry_q.last_reported[31], entry_q.last_reported};
    diff_abs   = diff[32] ? 33'(-diff) : 33'(diff);
    change     = hr ? diff_abs[31:0] : 32'd0;
    elapsed    = item_q.now_sec - entry_q.last_period_time;
    period_due = !hp || (elapsed >= {16'd0, entry_q.interval});
    db_nz      = entry_q.deadband != 31'd0;
    chg_ge     = change >= {1'b0, entry_q.deadband};
    report     = 1'b0;
    reason     = REASON_FIRST;
    case (entry_q.policy)
      POL_PERIODIC: begin
        if (period_due) begin
          report = 1'b1;
          reason = REASON_PERIOD;
        end
      end
      POL_ON_CHANGE: begin
        if (!hr) begin
          report = 1'b1;
          reason = REASON_FIRST;
        end else if (db_nz ? chg_ge : (change > 32'd1)) begin
          report = 1'b1;
          reason = REASON_CHANGE;
        end
      end
      POL_MIXED: begin
        if (hr && db_nz && chg_ge) begin
          report = 1'b1;
          reason = REASON_CHANGE;
        end else if (period_due) begin
          report = 1'b1;
          reason = REASON_PERIOD;
        end
      end
      default: begin
        report = 1'b0;
      end
    endcase
  end

  // Shared divider step: shift in one dividend bit, subtract the step if it fits.
  logic [31:0] rem_sh;
  logic        rem_ge;
  logic [31:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q[30:0], dvd_q[31]};
    rem_ge = rem_sh >= {1'b0, entry_q.step};
    rem_nx = rem_ge ? (rem_sh - {1'b0, entry_q.step}) : rem_sh;
  end

  // Final rounding add and saturation.
  logic [32:0] res;
  logic [31:0] sat;

  always_comb begin
    res = {1'b0, base_q} + (up_q ? {2'b00, entry_q.step} : 33'd0);
    if (neg_q) begin
      sat = (res > 33'h080000000) ? 32'h80000000 : (~res[31:0] + 32'd1);
    end else begin
      sat = (res > 33'h07FFFFFFF) ? 32'h7FFFFFFF : res[31:0];
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_slot_ok && (in_i.payload.func == FUNC_SAMPLE)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (!report) begin
          state_d = ST_IDLE;
        end else if (entry_q.step == 31'd0) begin
          state_d = ST_ADJ;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == 5'd31) begin
          state_d = ST_ADJ;
        end
      end
      ST_ADJ: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    finish_go = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready  = 1'b1;
      ST_FINISH: finish_go = !out_valid_q || out_o.ready;
      default: begin
        in_ready  = 1'b0;
        finish_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Settings and history memory: load writes in idle, a report writes at finish.
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  pdrf_entry_t     mem_wdata;
  logic            load_we;

  always_comb begin
    load_we   = in_xfer && in_slot_ok && (in_i.payload.func == FUNC_LOAD);
    mem_we    = load_we || finish_go;
    mem_waddr = load_we ? in_idx : idx_q;
    if (load_we) begin
      mem_wdata.policy           = in_i.payload.policy_in;
      mem_wdata.interval         = in_i.payload.interval_in;
      mem_wdata.deadband         = in_i.payload.deadband_in;
      mem_wdata.step             = in_i.payload.step_in;
      mem_wdata.last_reported    = 32'sd0;
      mem_wdata.last_period_time = 32'd0;
    end else begin
      mem_wdata                  = entry_q;
      mem_wdata.last_reported    = rounded_q;
      mem_wdata.last_period_time = item_q.now_sec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_READ) begin
      entry_q <= mem[idx_q];
    end
  end

  // Per-slot history flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_rep_q <= '0;
      has_per_q <= '0;
    end else if (load_we) begin
      has_rep_q[in_idx] <= 1'b0;
      has_per_q[in_idx] <= 1'b0;
    end else if (finish_go) begin
      has_rep_q[idx_q] <= 1'b1;
      if (entry_q.policy != POL_ON_CHANGE) begin
        has_per_q[idx_q] <= 1'b1;
      end
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          item_q <= in_i.payload;
          idx_q  <= in_idx;
        end
      end
      ST_EVAL: begin
        reason_q <= reason;
        change_q <= change;
        neg_q    <= item_q.sample_value[31];
        mag_q    <= item_q.sample_value[31] ? (~item_q.sample_value + 32'd1)
                                            : item_q.sample_value;
        dvd_q    <= item_q.sample_value[31] ? (~item_q.sample_value + 32'd1)
                                            : item_q.sample_value;
        rem_q    <= 32'd0;
        cnt_q    <= 5'd0;
      end
      ST_DIV: begin
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[30:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
      end
      ST_ADJ: begin
        base_q <= mag_q - rem_q;
        up_q   <= {rem_q, 1'b0} >= {2'b00, entry_q.step};
      end
      ST_ROUND: begin
        rounded_q <= sat;
      end
      default: begin
      end
    endcase
  end

  // Output register: filled at finish, emptied by a transfer on the sink side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_go) begin
      out_q.slot_out       <= item_q.slot;
      out_q.reported_value <= rounded_q;
      out_q.reason         <= reason_q;
      out_q.policy_out     <= entry_q.policy;
      out_q.change_amount  <= change_q;
    end
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

FILE: tb/pdrf_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrf_report_checker: scoreboard for the periodic deadband report filter
// Watches both channels. It keeps its own per-slot settings and history,
// works out the report that each accepted sample should give, and checks
// every report transfer field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module pdrf_report_checker
  import pdrf_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdrf_in_if          in_i,
  pdrf_out_if         out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned report_count_o
);

  localparam longint I32Max = 64'sd2147483647;
  localparam longint I32Min = -64'sd2147483648;

  // Per-slot settings and report history.
  typedef struct {
    logic [1:0]         policy;
    logic [15:0]        interval;
    logic [30:0]        deadband;
    logic [30:0]        step;
    logic signed [31:0] prev_rounded;
    logic [31:0]        last_time;
    bit                 has_report;
    bit                 has_time;
  } slot_book_t;

  slot_book_t  slot_book [SLOT_COUNT];
  pdrf_out_t   expected_reports [$];
  int unsigned fails = 0;
  int unsigned reports_seen = 0;

  assign fail_count_o   = fails;
  assign pending_o      = expected_reports.size();
  assign report_count_o = reports_seen;

  // Round half away from zero to a multiple of the step, then saturate.
  function automatic logic signed [31:0] round_to_step(logic signed [31:0] v,
                                                       logic [30:0] stp);
    longint mag, st, q, r, res;
    if (stp == '0) return v;
    st  = longint'(stp);
    mag = longint'(v);
    if (mag < 0) mag = -mag;
    q = mag / st;
    r = mag % st;
    if (2 * r >= st) q++;
    res = q * st;
    if (v < 0) res = -res;
    if (res > I32Max) res = I32Max;
    if (res < I32Min) res = I32Min;
    return res[31:0];
  endfunction

  // Apply one accepted item to the slot history; returns 1 when it reports.
  function automatic bit predict_report(input pdrf_in_t it, output pdrf_out_t rep);
    logic [3:0]         s;
    logic signed [31:0] value;
    logic [31:0]        change;
    logic [31:0]        elapsed;
    logic [1:0]         why;
    longint             diff;
    bit                 due;
    bit                 fire;
    s      = it.slot;
    value  = $signed(it.sample_value);
    change = '0;
    why    = REASON_FIRST;
    fire   = 1'b0;
    rep    = '0;
    if (it.slot >= SLOT_COUNT) return 1'b0;

    // A load rewrites the settings and forgets the history.
    if (it.func == FUNC_LOAD) begin
      slot_book[s].policy     = it.policy_in;
      slot_book[s].interval   = it.interval_in;
      slot_book[s].deadband   = it.deadband_in;
      slot_book[s].step       = it.step_in;
      slot_book[s].has_report = 1'b0;
      slot_book[s].has_time   = 1'b0;
      return 1'b0;
    end

    if (slot_book[s].has_report) begin
      diff = longint'(value) - longint'(slot_book[s].prev_rounded);
      if (diff < 0) diff = -diff;
      change = diff[31:0];
    end
    elapsed = it.now_sec - slot_book[s].last_time;
    due = !slot_book[s].has_time || (elapsed >= 32'(slot_book[s].interval));

    case (slot_book[s].policy)
      POL_PERIODIC: begin
        if (due) begin
          fire = 1'b1;
          why  = REASON_PERIOD;
        end
      end
      POL_ON_CHANGE: begin
        if (!slot_book[s].has_report) begin
          fire = 1'b1;
          why  = REASON_FIRST;
        end else if (slot_book[s].deadband != '0) begin
          if (change >= 32'(slot_book[s].deadband)) begin
            fire = 1'b1;
            why  = REASON_CHANGE;
          end
        end else if (change > 32'd1) begin
          fire = 1'b1;
          why  = REASON_CHANGE;
        end
      end
      POL_MIXED: begin
        if (slot_book[s].has_report && slot_book[s].deadband != '0 &&
            change >= 32'(slot_book[s].deadband)) begin
          fire = 1'b1;
          why  = REASON_CHANGE;
        end else if (due) begin
          fire = 1'b1;
          why  = REASON_PERIOD;
        end
      end
      default: begin
        // The unused policy code is stored but never reports.
      end
    endcase
    if (!fire) return 1'b0;

    // Every report except on-change restarts the period timer.
    if (slot_book[s].policy != POL_ON_CHANGE) begin
      slot_book[s].last_time = it.now_sec;
      slot_book[s].has_time  = 1'b1;
    end
    slot_book[s].prev_rounded = round_to_step(value, slot_book[s].step);
    slot_book[s].has_report   = 1'b1;

    rep.slot_out       = s;
    rep.reported_value = slot_book[s].prev_rounded;
    rep.reason         = why;
    rep.policy_out     = slot_book[s].policy;
    rep.change_amount  = change;
    return 1'b1;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: report field %s expected 0x%08h, actual 0x%08h",
               $time, field, want, got);
    end
  endfunction

  // Inputs are handled before outputs so a report is matched against an
  // expectation queued at the same or an earlier edge.
  always @(posedge clk_i or negedge rst_ni) begin
    pdrf_out_t want;
    pdrf_out_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_book[i] = '{default: '0};
      expected_reports.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        if (predict_report(in_i.payload, want)) expected_reports.push_back(want);
      end
      if (out_i.valid && out_i.ready) begin
        got = out_i.payload;
        reports_seen++;
        if (expected_reports.size() == 0) begin
          fails++;
          $display("%0t: report transfer for slot %0d with none expected",
                   $time, got.slot_out);
        end else begin
          want = expected_reports.pop_front();
          check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
          check_field("reported_value", want.reported_value, got.reported_value);
          check_field("reason", 32'(want.reason), 32'(got.reason));
          check_field("policy_out", 32'(want.policy_out), 32'(got.policy_out));
          check_field("change_amount", want.change_amount, got.change_amount);
        end
      end
    end
  end

endmodule

FILE: tb/tb_periodic_deadband_report_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_deadband_report_filter: stimulus and verdict for the filter
// A directed opening covers each policy, the first-check and reload rules,
// the silent policy code and rounding saturation; random phases then drive
// slot-wise value walks and a running clock under varied handshake pressure.
// ----------------------------------------------------------------------------
module tb_periodic_deadband_report_filter;
  import pdrf_pkg::*;

  localparam int unsigned SlotCount      = SlotCountDef;
  localparam logic [1:0]  POL_SILENT     = 2'd3;
  localparam int          RandomPerPhase = 332;
  localparam int          HoldCycles     = 500;
  localparam int          DrainCycles    = 100;

  localparam logic signed [31:0] ValMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] ValMin = 32'sh8000_0000;
  localparam logic [30:0]        Max31  = 31'h7fff_ffff;

  logic clk_i;
  logic rst_ni;

  pdrf_in_if  in_ch ();
  pdrf_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending_reports;
  int unsigned report_count;

  // Stimulus bookkeeping.
  bit                 slot_loaded [SlotCount];
  logic signed [31:0] slot_level [SlotCount];
  logic [31:0]        clock_sec;
  int unsigned        sender_idle_pct;
  int unsigned        stall_pct;
  bit                 hold_req;
  int unsigned        loads_sent;
  int unsigned        samples_sent;

  periodic_deadband_report_filter #(
    .SLOT_COUNT(SlotCount)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  pdrf_report_checker #(
    .SLOT_COUNT(SlotCount)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .fail_count_o  (fail_count),
    .pending_o     (pending_reports),
    .report_count_o(report_count)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("periodic_deadband_report_filter: mismatch");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off counted here.
  initial begin : receiver
    int unsigned held;
    held = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && held < HoldCycles) begin
        out_ch.ready <= 1'b0;
        held++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Load item; the sample-only fields carry noise.
  function automatic pdrf_in_t load_item(logic [3:0] s, logic [1:0] pol,
                                         logic [15:0] ivl, logic [30:0] db,
                                         logic [30:0] stp);
    pdrf_in_t it;
    it.func         = FUNC_LOAD;
    it.slot         = s;
    it.sample_value = $urandom;
    it.now_sec      = $urandom;
    it.policy_in    = pol;
    it.interval_in  = ivl;
    it.deadband_in  = db;
    it.step_in      = stp;
    slot_loaded[s]  = 1'b1;
    return it;
  endfunction

  // Sample item; the load-only fields carry noise.
  function automatic pdrf_in_t sample_item(logic [3:0] s, logic signed [31:0] v,
                                           logic [31:0] t);
    pdrf_in_t it;
    it.func         = FUNC_SAMPLE;
    it.slot         = s;
    it.sample_value = v;
    it.now_sec      = t;
    it.policy_in    = 2'($urandom_range(3));
    it.interval_in  = 16'($urandom);
    it.deadband_in  = 31'($urandom);
    it.step_in      = 31'($urandom);
    slot_level[s]   = v;
    return it;
  endfunction

  // Offer one item after a random idle gap and wait for its transfer.
  task automatic offer_item(input pdrf_in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.func == FUNC_LOAD) loads_sent++;
    else samples_sent++;
  endtask

  // Random phase: mostly samples on loaded slots with a slow value walk and
  // a running clock, with occasional reloads, jumps and extreme values.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                           input bit with_hold);
    int unsigned        s;
    int unsigned        r;
    logic [1:0]         pol;
    logic [15:0]        ivl;
    logic [30:0]        db;
    logic [30:0]        stp;
    logic signed [31:0] v;
    sender_idle_pct = idle_pct;
    stall_pct       = stall;
    for (int n = 0; n < RandomPerPhase; n++) begin
      if (with_hold && n == RandomPerPhase / 4) hold_req = 1'b1;
      s = $urandom_range(SlotCount - 1);
      if (!slot_loaded[s] || $urandom_range(99) < 8) begin
        case ($urandom_range(9))
          0:       pol = POL_SILENT;
          1, 2, 3: pol = POL_PERIODIC;
          4, 5, 6: pol = POL_ON_CHANGE;
          default: pol = POL_MIXED;
        endcase
        r = $urandom_range(9);
        if (r < 7)      ivl = 16'($urandom_range(6));
        else if (r < 9) ivl = 16'($urandom_range(300));
        else            ivl = 16'($urandom);
        r = $urandom_range(9);
        if (r < 5)      db = 31'($urandom_range(40));
        else if (r < 7) db = '0;
        else if (r < 9) db = 31'($urandom_range(5000));
        else            db = 31'($urandom);
        r = $urandom_range(9);
        if (r < 4)      stp = '0;
        else if (r < 8) stp = 31'($urandom_range(100, 1));
        else if (r < 9) stp = 31'($urandom_range(10000, 1));
        else            stp = 31'($urandom);
        offer_item(load_item(4'(s), pol, ivl, db, stp));
      end else begin
        case ($urandom_range(19))
          0: begin
            case ($urandom_range(4))
              0:       v = ValMax;
              1:       v = ValMin;
              2:       v = 32'sd0;
              3:       v = -32'sd1;
              default: v = 32'sd1;
            endcase
          end
          1, 2:    v = $urandom;
          3:       v = slot_level[s];
          default: v = slot_level[s] + 32'($urandom_range(120)) - 32'sd60;
        endcase
        case ($urandom_range(19))
          0:       clock_sec = $urandom;
          1:       clock_sec = clock_sec + $urandom_range(70000);
          default: clock_sec = clock_sec + $urandom_range(3);
        endcase
        offer_item(sample_item(4'(s), v, clock_sec));
      end
    end
  endtask

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.payload   = '0;
    hold_req        = 1'b0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    clock_sec       = 32'd5000;
    loads_sent      = 0;
    samples_sent    = 0;
    for (int i = 0; i < SlotCount; i++) slot_level[i] = 32'sd0;
    rst_ni          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Periodic: the first check counts as elapsed, then the interval rules.
    offer_item(load_item(4'd0, POL_PERIODIC, 16'd5, 31'd0, 31'd0));
    offer_item(sample_item(4'd0, 32'sd123, 32'd1000));
    offer_item(sample_item(4'd0, 32'sd124, 32'd1004));
    offer_item(sample_item(4'd0, 32'sd125, 32'd1005));
    // On change with a zero deadband: a change of one is not enough.
    offer_item(load_item(4'd1, POL_ON_CHANGE, 16'd0, 31'd0, 31'd0));
    offer_item(sample_item(4'd1, 32'sd100, 32'd1006));
    offer_item(sample_item(4'd1, 32'sd101, 32'd1007));
    offer_item(sample_item(4'd1, 32'sd102, 32'd1008));
    // Mixed: first on the period, then a change that restarts the timer.
    offer_item(load_item(4'd2, POL_MIXED, 16'd10, 31'd50, 31'd10));
    offer_item(sample_item(4'd2, 32'sd15, 32'd2000));
    offer_item(sample_item(4'd2, -32'sd65, 32'd2001));
    offer_item(sample_item(4'd2, -32'sd70, 32'd2011));
    // Widest interval and deadband; time wraps; full-range change amount.
    offer_item(load_item(4'd3, POL_PERIODIC, 16'hffff, Max31, 31'd2));
    offer_item(sample_item(4'd3, ValMax, 32'hffff_fff0));
    offer_item(sample_item(4'd3, ValMin, 32'h0000_ffef));
    // Negative saturation on rounding, then an unchanged value.
    offer_item(load_item(4'd4, POL_ON_CHANGE, 16'd0, 31'd1, 31'd3));
    offer_item(sample_item(4'd4, ValMin, 32'd3000));
    offer_item(sample_item(4'd4, ValMin, 32'd3001));
    // The unused policy code never reports.
    offer_item(load_item(4'd5, POL_SILENT, 16'd0, 31'd0, Max31));
    offer_item(sample_item(4'd5, 32'sd7, 32'd3002));
    // Largest step rounds half of the range up to the maximum.
    offer_item(load_item(4'd15, POL_MIXED, 16'd0, 31'd0, Max31));
    offer_item(sample_item(4'd15, 32'sh4000_0000, 32'd3003));
    // A reload forgets the history, so the timer counts as elapsed again.
    offer_item(load_item(4'd0, POL_PERIODIC, 16'd5, 31'd0, 31'd0));
    offer_item(sample_item(4'd0, 32'sd125, 32'd3004));

    run_phase(0, 0, 1'b1);
    run_phase(84, 0, 1'b0);
    clock_sec = 32'hffff_fe00;
    run_phase(0, 84, 1'b0);
    run_phase(23, 23, 1'b0);
    in_ch.valid <= 1'b0;

    // Let the checker queue the last transfer, then drain.
    @(posedge clk_i);
    wait (pending_reports == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d load and %0d sample transfers under four handshake mixes",
             loads_sent, samples_sent);
    $display("and a %0d-cycle output hold-off; %0d reports were compared.",
             HoldCycles, report_count);
    if (fail_count == 0) begin
      $display("periodic_deadband_report_filter: match");
    end else begin
      $display("periodic_deadband_report_filter: mismatch");
    end
    $finish;
  end

endmodule
